[design/orng_pkg.sv]
// ----------------------------------------------------------------------------
// orng_pkg: shared types and constants for the outlier range detector
// Field widths, register index codes, reset values and the request
// structures that travel between the detector's stages.
// ----------------------------------------------------------------------------
package orng_pkg;

    localparam int TIME_W      = 32;
    localparam int SAMPLE_W    = 32;
    localparam int CFG_W       = 16;
    localparam int CFG_ADDR_W  = 2;
    localparam int COUNT_W     = 32;
    localparam int SCALE_SHIFT = 8;
    // Width of threshold * spread, with the unsigned threshold given a sign bit.
    localparam int PROD_W      = SAMPLE_W + CFG_W + 1;
    localparam int GUARD_W     = PROD_W - (SAMPLE_W + 1) - SCALE_SHIFT;

    localparam logic [CFG_ADDR_W-1:0] REG_THRESHOLD  = CFG_ADDR_W'(0);
    localparam logic [CFG_ADDR_W-1:0] REG_SKIP_COUNT = CFG_ADDR_W'(1);
    localparam logic [CFG_ADDR_W-1:0] REG_BORDER     = CFG_ADDR_W'(2);

    localparam logic [CFG_W-1:0] THRESHOLD_RST  = CFG_W'(1280);
    localparam logic [CFG_W-1:0] SKIP_COUNT_RST = CFG_W'(50);
    localparam logic [CFG_W-1:0] BORDER_RST     = CFG_W'(10);

    localparam logic [COUNT_W-1:0] COUNT_MAX = {COUNT_W{1'b1}};

    typedef struct packed {
        logic        [TIME_W-1:0]   time_index;
        logic signed [SAMPLE_W-1:0] power;
        logic signed [SAMPLE_W-1:0] median_level;
        logic signed [SAMPLE_W-1:0] spread;
        logic                       is_last;
    } orng_in_t;

    typedef struct packed {
        logic [TIME_W-1:0] range_start;
        logic [TIME_W-1:0] range_end;
    } orng_out_t;

    typedef struct packed {
        logic [CFG_W-1:0] threshold;
        logic [CFG_W-1:0] skip_count;
        logic [CFG_W-1:0] border;
    } orng_cfg_t;

    typedef struct packed {
        logic signed [PROD_W-1:0] lhs;
        logic signed [PROD_W-1:0] rhs;
        logic        [TIME_W-1:0] time_index;
        logic                     is_last;
    } orng_prod_t;

endpackage

[design/orng_cfg_regs.sv]
// ----------------------------------------------------------------------------
// orng_cfg_regs: configuration registers
// Holds threshold, skip count and border; writes to unused indexes are dropped.
// ----------------------------------------------------------------------------
module orng_cfg_regs (
    input  logic                           aclk,
    input  logic                           aresetn,
    input  logic                           cfg_wr_en,
    input  logic [orng_pkg::CFG_ADDR_W-1:0] cfg_addr,
    input  logic [orng_pkg::CFG_W-1:0]      cfg_wr_data,
    output orng_pkg::orng_cfg_t             cfg
);
    import orng_pkg::*;

    orng_cfg_t cfg_reg;
    orng_cfg_t cfg_next;

    always_comb begin
        cfg_next = cfg_reg;
        if (cfg_wr_en) begin
            case (cfg_addr)
                REG_THRESHOLD:  cfg_next.threshold  = cfg_wr_data;
                REG_SKIP_COUNT: cfg_next.skip_count = cfg_wr_data;
                REG_BORDER:     cfg_next.border     = cfg_wr_data;
                default:        cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.threshold  <= THRESHOLD_RST;
            cfg_reg.skip_count <= SKIP_COUNT_RST;
            cfg_reg.border     <= BORDER_RST;
        end else begin
            cfg_reg <= cfg_next;
        end
    end

    assign cfg = cfg_reg;

endmodule

[design/orng_product_stage.sv]
// ----------------------------------------------------------------------------
// orng_product_stage: input register and scaled product register
// Registers each sample request, then forms (power - median) * 256 and
// threshold * spread so the tracker only has to compare them.
// ----------------------------------------------------------------------------
module orng_product_stage (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  s_valid,
    output logic                  s_ready,
    input  orng_pkg::orng_in_t    s_data,
    input  logic [orng_pkg::CFG_W-1:0] threshold,
    output logic                  prod_valid,
    input  logic                  prod_ready,
    output orng_pkg::orng_prod_t  prod
);
    import orng_pkg::*;

    logic       in_valid_reg;
    logic       in_valid_next;
    orng_in_t   in_reg;
    logic       prod_valid_reg;
    logic       prod_valid_next;
    orng_prod_t prod_reg;
    orng_prod_t prod_next;
    logic       adv_prod;
    logic       adv_in;

    logic signed [SAMPLE_W:0]   diff;
    logic signed [CFG_W:0]      thr_s;

    // Each stage moves when it is empty or the stage after it takes its request.
    assign adv_prod = !prod_valid_reg || prod_ready;
    assign adv_in   = !in_valid_reg || adv_prod;
    assign s_ready  = adv_in;

    assign in_valid_next   = adv_in ? s_valid : in_valid_reg;
    assign prod_valid_next = adv_prod ? in_valid_reg : prod_valid_reg;

    always_comb begin
        diff  = {in_reg.power[SAMPLE_W-1], in_reg.power}
              - {in_reg.median_level[SAMPLE_W-1], in_reg.median_level};
        thr_s = $signed({1'b0, threshold});
        prod_next.lhs        = {{GUARD_W{diff[SAMPLE_W]}}, diff, {SCALE_SHIFT{1'b0}}};
        prod_next.rhs        = PROD_W'(thr_s * in_reg.spread);
        prod_next.time_index = in_reg.time_index;
        prod_next.is_last    = in_reg.is_last;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg   <= 1'b0;
            prod_valid_reg <= 1'b0;
        end else begin
            in_valid_reg   <= in_valid_next;
            prod_valid_reg <= prod_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_valid && adv_in) begin
            in_reg <= s_data;
        end
        if (in_valid_reg && adv_prod) begin
            prod_reg <= prod_next;
        end
    end

    assign prod_valid = prod_valid_reg;
    assign prod       = prod_reg;

endmodule

[design/orng_tracker.sv]
// ----------------------------------------------------------------------------
// orng_tracker: range state and result register
// Flags samples, opens and closes ranges, and holds the finished range
// until the downstream side takes it.
// ----------------------------------------------------------------------------
module orng_tracker (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  orng_pkg::orng_cfg_t  cfg,
    input  logic                 prod_valid,
    output logic                 prod_ready,
    input  orng_pkg::orng_prod_t prod,
    output logic                 m_valid,
    input  logic                 m_ready,
    output orng_pkg::orng_out_t  m_data
);
    import orng_pkg::*;

    logic [COUNT_W-1:0] count_reg,   count_next;
    logic               open_reg,    open_next;
    logic [TIME_W-1:0]  start_reg,   start_next;
    logic [COUNT_W-1:0] flagged_reg, flagged_next;
    logic [TIME_W-1:0]  prev_reg,    prev_next;
    logic               m_valid_reg, m_valid_next;
    orng_out_t          m_data_reg,  m_data_next;

    logic               consume;
    logic               active;
    logic               flagged;
    logic               gap_ok;
    logic               close_gap;
    logic               close_last;
    logic               open_after;
    logic [TIME_W-1:0]  start_after;
    logic [TIME_W-1:0]  border_t;

    assign prod_ready = !m_valid_reg || m_ready;
    assign consume    = prod_valid && prod_ready;
    assign border_t   = TIME_W'(cfg.border);

    always_comb begin
        active    = count_reg >= COUNT_W'(cfg.skip_count);
        flagged   = active && (prod.lhs > prod.rhs);
        // The gap is taken modulo the counter width, as the count saturates.
        gap_ok    = (count_reg - flagged_reg) > COUNT_W'(cfg.border);
        close_gap = active && !flagged && open_reg && gap_ok;

        open_after  = open_reg;
        start_after = start_reg;
        if (flagged && !open_reg) begin
            open_after  = 1'b1;
            start_after = prod.time_index;
        end
        close_last = prod.is_last && open_after && !close_gap;

        m_data_next.range_start = (start_after > border_t) ? (start_after - border_t)
                                                           : '0;
        m_data_next.range_end   = close_gap ? prev_reg : prod.time_index;

        m_valid_next = m_valid_reg && !m_ready;
        if (consume && (close_gap || close_last)) begin
            m_valid_next = 1'b1;
        end

        count_next   = (count_reg == COUNT_MAX) ? count_reg : count_reg + COUNT_W'(1);
        open_next    = open_after && !close_gap;
        start_next   = start_after;
        flagged_next = flagged ? count_reg : flagged_reg;
        prev_next    = prod.time_index;
        // The last sample of a stream leaves the range state as after reset.
        if (prod.is_last) begin
            count_next   = '0;
            open_next    = 1'b0;
            start_next   = '0;
            flagged_next = '0;
            prev_next    = '0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            count_reg   <= '0;
            open_reg    <= 1'b0;
            start_reg   <= '0;
            flagged_reg <= '0;
            prev_reg    <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            m_valid_reg <= m_valid_next;
            if (consume) begin
                count_reg   <= count_next;
                open_reg    <= open_next;
                start_reg   <= start_next;
                flagged_reg <= flagged_next;
                prev_reg    <= prev_next;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (consume && (close_gap || close_last)) begin
            m_data_reg <= m_data_next;
        end
    end

    assign m_valid = m_valid_reg;
    assign m_data  = m_data_reg;

endmodule

[design/outlier_range_detector.sv]
// ----------------------------------------------------------------------------
// outlier_range_detector: power outlier range finder
// Flags power samples far above their running median and reports the time
// ranges they cover.
// ----------------------------------------------------------------------------
// One sample request is accepted every clock cycle while the result channel
// is not stalled. A sample passes through an input register, a product register
// holding (power - median) * 256 and threshold * spread, and the range
// tracker, whose result register then holds the range that the sample
// closes. The tracker updates its state as each sample is consumed, which
// sets the rate of one sample per cycle. While a result waits on m_ready,
// the two stages in front of the tracker still take up to two further
// samples before s_ready drops. Configuration writes take effect on the next
// cycle and must be made while no sample is in flight.
module outlier_range_detector (
    input  logic                            aclk,
    input  logic                            aresetn,
    input  logic                            s_valid,
    output logic                            s_ready,
    input  orng_pkg::orng_in_t              s_data,
    output logic                            m_valid,
    input  logic                            m_ready,
    output orng_pkg::orng_out_t             m_data,
    input  logic                            cfg_wr_en,
    input  logic [orng_pkg::CFG_ADDR_W-1:0] cfg_addr,
    input  logic [orng_pkg::CFG_W-1:0]      cfg_wr_data
);
    import orng_pkg::*;

    orng_cfg_t  cfg;
    logic       prod_valid;
    logic       prod_ready;
    orng_prod_t prod;

    orng_cfg_regs u_cfg_regs (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_addr    (cfg_addr),
        .cfg_wr_data (cfg_wr_data),
        .cfg         (cfg)
    );

    orng_product_stage u_product_stage (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .s_valid    (s_valid),
        .s_ready    (s_ready),
        .s_data     (s_data),
        .threshold  (cfg.threshold),
        .prod_valid (prod_valid),
        .prod_ready (prod_ready),
        .prod       (prod)
    );

    orng_tracker u_tracker (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .cfg        (cfg),
        .prod_valid (prod_valid),
        .prod_ready (prod_ready),
        .prod       (prod),
        .m_valid    (m_valid),
        .m_ready    (m_ready),
        .m_data     (m_data)
    );

endmodule

[design/orng_checker.sv]
// ----------------------------------------------------------------------------
// orng_checker: port-level checks for the outlier range detector
// Watches the result channel and the input ready over time.
// ----------------------------------------------------------------------------
module orng_checker (
    input logic                aclk,
    input logic                aresetn,
    input logic                s_ready,
    input logic                m_valid,
    input logic                m_ready,
    input orng_pkg::orng_out_t m_data
);
    import orng_pkg::*;

    // A result that is not taken stays on the port unchanged.
    a_result_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_data))
        else $error("result dropped or changed while stalled");

    // Reset empties the result register.
    a_reset_clears: assert property (@(posedge aclk)
        !aresetn |=> !m_valid)
        else $error("result valid right after reset");

    // With no result waiting, nothing can block a new sample request.
    a_ready_when_empty: assert property (@(posedge aclk) disable iff (!aresetn)
        !m_valid |-> s_ready)
        else $error("input stalled while no result is pending");

endmodule

bind outlier_range_detector orng_checker u_orng_checker (
    .aclk    (aclk),
    .aresetn (aresetn),
    .s_ready (s_ready),
    .m_valid (m_valid),
    .m_ready (m_ready),
    .m_data  (m_data)
);
